// ----- sv/tbc_pkg.sv -----
`default_nettype none

package tbc_pkg;

   // field widths
   localparam int FN_W   = 22;
   localparam int TN_W   = 3;
   localparam int CODE_W = 4;
   localparam int CORR_W = 3;
   localparam int MOD_W  = 7;
   localparam int REG_W  = 32;
   localparam int MODE_W = 2;
   localparam int IDX_W  = 1;

   typedef logic [FN_W-1:0]   fn_type;
   typedef logic [TN_W-1:0]   tn_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [CORR_W-1:0] corr_type;
   typedef logic [MOD_W-1:0]  mod_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // register indexes
   localparam idx_type REG_SLOT_TYPES = 1'd0;
   localparam idx_type REG_RX_MODE    = 1'd1;

   // receive modes
   localparam mode_type MODE_OFF     = 2'd0;
   localparam mode_type MODE_BASE    = 2'd1;
   localparam mode_type MODE_ACQUIRE = 2'd2;

   // expected burst types
   localparam corr_type CT_OFF  = 3'd0;
   localparam corr_type CT_IDLE = 3'd1;
   localparam corr_type CT_TSC  = 3'd2;
   localparam corr_type CT_RACH = 3'd3;
   localparam corr_type CT_SCH  = 3'd4;

   // channel combination codes
   localparam code_type SLOT_NONE     = 4'd0;
   localparam code_type SLOT_I        = 4'd1;
   localparam code_type SLOT_II       = 4'd2;
   localparam code_type SLOT_III      = 4'd3;
   localparam code_type SLOT_IV       = 4'd4;
   localparam code_type SLOT_V        = 4'd5;
   localparam code_type SLOT_VI       = 4'd6;
   localparam code_type SLOT_VII      = 4'd7;
   localparam code_type SLOT_XIII     = 4'd8;
   localparam code_type SLOT_FILL     = 4'd9;
   localparam code_type SLOT_LOOPBACK = 4'd10;

   // multiframe lengths
   localparam mod_type MF_26  = 7'd26;
   localparam mod_type MF_51  = 7'd51;
   localparam mod_type MF_52  = 7'd52;
   localparam mod_type MF_102 = 7'd102;

   // reciprocal constants: q = (fn * RECIP) >> RECIP_SHIFT is the quotient or one less
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 28;
   localparam int PROD_W      = FN_W + RECIP_W;
   localparam int Q51_W       = 17;
   localparam int Q26_W       = 18;
   localparam logic [RECIP_W-1:0] RECIP_51 = 24'd5263440;
   localparam logic [RECIP_W-1:0] RECIP_26 = 24'd10324440;

   typedef struct packed {
      corr_type corr;
      logic     process;
      mod_type  modulus;
      mod_type  filler;
      logic     tx_zero;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/tbc_map.sv -----
`default_nettype none

module tbc_map (
   input  tbc_pkg::code_type   code,
   input  tbc_pkg::mode_type   mode,
   input  tbc_pkg::mod_type    m26,
   input  tbc_pkg::mod_type    m51,
   input  tbc_pkg::mod_type    m52,
   input  tbc_pkg::mod_type    m102,
   output tbc_pkg::result_type result
);
   import tbc_pkg::*;

   corr_type slot_corr;
   mod_type  modulus;
   mod_type  filler;

   // expected burst per combination
   always_comb begin
      case (code)
         SLOT_NONE:                   slot_corr = CT_OFF;
         SLOT_I, SLOT_II, SLOT_III:   slot_corr = CT_TSC;
         SLOT_IV, SLOT_VI:            slot_corr = CT_RACH;
         SLOT_V: begin
            if ((m51 >= 7'd14 && m51 <= 7'd36) || m51 == 7'd4 || m51 == 7'd5 ||
                m51 == 7'd45 || m51 == 7'd46)
               slot_corr = CT_RACH;
            else
               slot_corr = CT_TSC;
         end
         SLOT_VII: begin
            slot_corr = (m51 >= 7'd12 && m51 <= 7'd14) ? CT_IDLE : CT_TSC;
         end
         SLOT_XIII: begin
            if (m52 == 7'd12 || m52 == 7'd38)
               slot_corr = CT_RACH;
            else if (m52 == 7'd25 || m52 == 7'd51)
               slot_corr = CT_IDLE;
            else
               slot_corr = CT_TSC;
         end
         SLOT_FILL:                   slot_corr = CT_IDLE;
         SLOT_LOOPBACK: begin
            slot_corr = (m51 >= 7'd48) ? CT_IDLE : CT_TSC;
         end
         default:                     slot_corr = CT_OFF;
      endcase
   end

   // multiframe length and filler index
   always_comb begin
      case (code)
         SLOT_IV, SLOT_V, SLOT_VI: begin
            modulus = MF_51;
            filler  = m51;
         end
         SLOT_VII: begin
            modulus = MF_102;
            filler  = m102;
         end
         SLOT_XIII: begin
            modulus = MF_52;
            filler  = m52;
         end
         default: begin
            modulus = MF_26;
            filler  = m26;
         end
      endcase
   end

   always_comb begin
      result.modulus = modulus;
      result.filler  = filler;
      result.tx_zero = (code == SLOT_NONE);
      if (mode == MODE_ACQUIRE) begin
         result.corr    = CT_SCH;
         result.process = 1'b1;
      end else if (mode == MODE_BASE) begin
         result.corr    = slot_corr;
         result.process = (slot_corr == CT_TSC) || (slot_corr == CT_RACH);
      end else begin
         result.corr    = slot_corr;
         result.process = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tdma_burst_type_classifier.sv -----
`default_nettype none

// tdma burst type classifier
// request channel: req_valid / req_stall carry a frame number and timeslot; a
// request is taken at a clock edge with req_valid high and req_stall low
// response channel: rsp_valid / rsp_stall carry expected burst type, process
// flag, multiframe length, filler index and transmit-zero flag, one per request
// csr port: csr_we writes csr_wdata into register csr_index (0 slot codes,
// 1 receive mode); write only while no request is in flight
// pipeline: two register stages; a taken request passes the first stage register
// and then the response register before it can leave
// throughput: one request per cycle while rsp_stall is low; the first stage forms the quotients by
// 51 and 26 with two reciprocal multipliers, the second stage finishes the
// remainders and the slot lookup into the response register
// stall: the pipeline holds while rsp_stall is high and the response register
// is full; the first stage still takes a request if it is empty
// reset: clears both stage valid bits, the slot codes (all slots none) and the
// receive mode (off)
module tdma_burst_type_classifier (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tbc_pkg::fn_type        req_frame_number,
   input  tbc_pkg::tn_type        req_timeslot,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tbc_pkg::corr_type      rsp_corr_type,
   output logic                   rsp_process_burst,
   output tbc_pkg::mod_type       rsp_multiframe_modulus,
   output tbc_pkg::mod_type       rsp_filler_index,
   output logic                   rsp_transmit_zero,
   input  logic                   csr_we,
   input  tbc_pkg::idx_type       csr_index,
   input  logic [tbc_pkg::REG_W-1:0] csr_wdata
);
   import tbc_pkg::*;

   // configuration registers
   logic [REG_W-1:0] slot_types_ff;
   mode_type         rx_mode_ff;

   // first stage
   logic              s1_valid_ff;
   fn_type            s1_fn_ff;
   code_type          s1_code_ff;
   logic [Q51_W-1:0]  s1_q51_ff;
   logic [Q26_W-1:0]  s1_q26_ff;

   // response register
   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;

   logic              out_ready;
   logic              s1_ready;
   logic              req_take;
   logic              s1_move;
   code_type          req_code;
   logic [PROD_W-1:0] prod51;
   logic [PROD_W-1:0] prod26;

   fn_type  rem51_raw;
   fn_type  rem26_raw;
   logic    fix51;
   logic    fix26;
   mod_type m51;
   mod_type m26;
   mod_type m52;
   mod_type m102;

   // handshake
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;
   assign req_take  = req_valid && s1_ready;
   assign s1_move   = s1_valid_ff && out_ready;

   // slot code for this timeslot
   assign req_code = slot_types_ff[{req_timeslot, 2'b00} +: CODE_W];

   // approximate quotients, low by at most one
   assign prod51 = PROD_W'(req_frame_number) * PROD_W'(RECIP_51);
   assign prod26 = PROD_W'(req_frame_number) * PROD_W'(RECIP_26);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_types_ff <= '0;
         rx_mode_ff    <= MODE_OFF;
      end else if (csr_we) begin
         case (csr_index)
            REG_SLOT_TYPES: slot_types_ff <= csr_wdata;
            REG_RX_MODE:    rx_mode_ff    <= csr_wdata[MODE_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         s1_fn_ff   <= req_frame_number;
         s1_code_ff <= req_code;
         s1_q51_ff  <= prod51[RECIP_SHIFT +: Q51_W];
         s1_q26_ff  <= prod26[RECIP_SHIFT +: Q26_W];
      end
   end

   // remainders with one correction step; the parity of the true quotient
   // picks the upper half of the double-length multiframes
   assign rem51_raw = s1_fn_ff - (FN_W'(s1_q51_ff) * FN_W'(MF_51));
   assign rem26_raw = s1_fn_ff - (FN_W'(s1_q26_ff) * FN_W'(MF_26));
   assign fix51     = rem51_raw[MOD_W-1:0] >= MF_51;
   assign fix26     = rem26_raw[MOD_W-1:0] >= MF_26;
   assign m51       = fix51 ? rem51_raw[MOD_W-1:0] - MF_51 : rem51_raw[MOD_W-1:0];
   assign m26       = fix26 ? rem26_raw[MOD_W-1:0] - MF_26 : rem26_raw[MOD_W-1:0];
   assign m102      = (s1_q51_ff[0] ^ fix51) ? m51 + MF_51 : m51;
   assign m52       = (s1_q26_ff[0] ^ fix26) ? m26 + MF_26 : m26;

   tbc_map u_map (
      .code   (s1_code_ff),
      .mode   (rx_mode_ff),
      .m26    (m26),
      .m51    (m51),
      .m52    (m52),
      .m102   (m102),
      .result (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_corr_type          = out_ff.corr;
   assign rsp_process_burst      = out_ff.process;
   assign rsp_multiframe_modulus = out_ff.modulus;
   assign rsp_filler_index       = out_ff.filler;
   assign rsp_transmit_zero      = out_ff.tx_zero;

   // filler index always inside its multiframe
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_filler_index < rsp_multiframe_modulus)
      else $error("filler index out of multiframe range");

   // a held first stage item is not dropped
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff && $stable(s1_fn_ff))
      else $error("first stage lost a request");

   // no detection while the receiver is off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_process_burst |-> rx_mode_ff == MODE_BASE || rx_mode_ff == MODE_ACQUIRE)
      else $error("process flag set with receiver off");

   // unused slot gives off unless acquiring
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transmit_zero && rx_mode_ff != MODE_ACQUIRE |-> rsp_corr_type == CT_OFF)
      else $error("unused slot reports a burst");

endmodule

`default_nettype wire
